// ===== rtl/gvp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gvp_pkg: shared types, constants and tables
// Request and result formats, parameter codes, log-domain constants and the
// ln(1+2^-i) table used by the log and exponential units.
// ----------------------------------------------------------------------------
package gvp_pkg;

	localparam int MAX_GAUSS_DEF = 16;
	localparam int NUM_CLASSES   = 6;
	localparam int NUM_REGS      = 7;

	localparam int LW  = 48;
	localparam int LNW = 40;
	localparam int DW  = 80;
	localparam int QW  = 41;

	localparam int LN2_VAL    = 45426;
	localparam int EXP_LIMIT  = 40 * LN2_VAL;

	localparam logic signed [LW-1:0] LOG_FLOOR = 48'shFF00_0000_0000;
	localparam logic signed [LW-1:0] GAUSS_OFS = -48'sd605336;
	localparam logic signed [LW-1:0] LL_OFS    = 48'sd1362780;
	localparam logic signed [LW-1:0] LL_MAX    = 48'sd2147483647;
	localparam logic signed [LW-1:0] LL_MIN    = -48'sd2147483648;
	localparam logic [QW-1:0]        QUAD_CAP  = 41'h100_0000_0000;

	localparam logic       ACT_WRITE  = 1'b0;
	localparam logic [1:0] KIND_MIX   = 2'd0;
	localparam logic [1:0] KIND_MEAN  = 2'd1;
	localparam logic [1:0] KIND_VAR   = 2'd2;
	localparam logic [1:0] KIND_CLASS = 2'd3;
	localparam logic [2:0] REG_TOTAL  = 3'd0;
	localparam logic [2:0] REG_COUNT0 = 3'd1;

	typedef struct packed {
		logic        action;
		logic [15:0] intensity;
		logic [15:0] bias_gain;
		logic [7:0]  prior_c0;
		logic [7:0]  prior_c1;
		logic [7:0]  prior_c2;
		logic [7:0]  prior_c3;
		logic [7:0]  prior_c4;
		logic [7:0]  prior_c5;
		logic [1:0]  param_kind;
		logic [3:0]  param_index;
		logic [31:0] param_value;
	} voxel_t;

	typedef struct packed {
		logic [3:0]         gaussian_index;
		logic [2:0]         class_index;
		logic [15:0]        posterior;
		logic signed [31:0] log_likelihood;
		logic               last;
	} result_t;

	function automatic logic [4:0] reg_reset(input logic [2:0] i);
		case (i)
			3'd0: reg_reset = 5'd12;
			3'd4: reg_reset = 5'd3;
			3'd5: reg_reset = 5'd4;
			3'd6: reg_reset = 5'd2;
			default: reg_reset = 5'd1;
		endcase
	endfunction

	function automatic logic [16:0] ln_tab(input logic [4:0] i);
		case (i)
			5'd1:  ln_tab = 17'd26573;
			5'd2:  ln_tab = 17'd14624;
			5'd3:  ln_tab = 17'd7719;
			5'd4:  ln_tab = 17'd3973;
			5'd5:  ln_tab = 17'd2017;
			5'd6:  ln_tab = 17'd1016;
			5'd7:  ln_tab = 17'd510;
			5'd8:  ln_tab = 17'd256;
			5'd9:  ln_tab = 17'd128;
			5'd10: ln_tab = 17'd64;
			5'd11: ln_tab = 17'd32;
			5'd12: ln_tab = 17'd16;
			5'd13: ln_tab = 17'd8;
			5'd14: ln_tab = 17'd4;
			5'd15: ln_tab = 17'd2;
			5'd16: ln_tab = 17'd1;
			default: ln_tab = 17'd45426;
		endcase
	endfunction

endpackage
`default_nettype wire

// ===== rtl/gmm_voxel_posterior.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gmm_voxel_posterior: Gaussian mixture posterior responsibilities
// Holds the mixture table in memories and runs three passes per voxel over
// the active Gaussians: log joint density, exponentials, posteriors.
//
//   channel  direction  handshake            content
//   voxel    in         voxel_valid/stall    parameter write or voxel
//   result   out        result_valid/stall   one posterior per Gaussian
//   cfg      in         cfg_valid/ready      Gaussian and class counts
//
// A parameter write is taken while idle. A voxel's run is set by eight serial
// logarithms (two more per Gaussian), the shared divider (41 steps per Gaussian
// in the first pass, 17 in the last) and an exponential per Gaussian.
// Reset loads the default counts; the table is undefined until written.
// A stalled result holds; the next request is taken while the last waits.
// ----------------------------------------------------------------------------
module gmm_voxel_posterior #(
	parameter int MAX_GAUSS = gvp_pkg::MAX_GAUSS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             voxel_valid,
	output logic                  voxel_stall,
	input  wire gvp_pkg::voxel_t  voxel,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output gvp_pkg::result_t      result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [4:0]       cfg_data
);
	import gvp_pkg::*;

	localparam int GW = $clog2(MAX_GAUSS);
	localparam int KW = $clog2(MAX_GAUSS + 1);

	typedef enum logic [4:0] {
		S_IDLE, S_PRI, S_LSUM_GO, S_LSUM_WT, S_LC_GO, S_LC_WT,
		S_GCLS, S_GMUL, S_LNV_GO, S_LNV_WT, S_LNM_GO, S_LNM_WT,
		S_DIV_GO, S_DIV_WT, S_GSUM1, S_GSUM2,
		S_ERD, S_EGO, S_EWT, S_LL_GO, S_LL_WT,
		S_PRD, S_PGO, S_PWT, S_POUT
	} seq_state_t;

	seq_state_t            state_q;
	logic [4:0]            reg_q [NUM_REGS];
	logic [15:0]           cw_q [NUM_CLASSES];
	logic [31:0]           bc_q [NUM_CLASSES];
	logic signed [LW-1:0]  logp_q [NUM_CLASSES];

	logic [15:0]  mw_mem  [MAX_GAUSS];
	logic [23:0]  mn_mem  [MAX_GAUSS];
	logic [31:0]  var_mem [MAX_GAUSS];
	logic signed [LW-1:0] q_mem [MAX_GAUSS];
	logic [32:0]  ex_mem  [MAX_GAUSS];
	logic [2:0]   cls_mem [MAX_GAUSS];

	logic [15:0]           mw_rd_q;
	logic [23:0]           mn_rd_q;
	logic [31:0]           var_rd_q;
	logic signed [LW-1:0]  q_rd_q;
	logic [32:0]           ex_rd_q;
	logic [2:0]            cls_rd_q;

	voxel_t                item_q;
	logic [25:0]           x_q;
	logic [2:0]            c_q;
	logic [7:0]            cum_q;
	logic [KW-1:0]         k_q;
	logic [KW-1:0]         kk_q;
	logic [34:0]           bsum_q;
	logic signed [LW-1:0]  lnsum_q;
	logic [31:0]           var_q;
	logic [51:0]           dsq_q;
	logic                  skip_q;
	logic signed [LW-1:0]  lnv_q;
	logic signed [LW-1:0]  lnm_q;
	logic [QW-1:0]         quad_q;
	logic signed [LW-1:0]  t_q;
	logic signed [LW-1:0]  maxq_q;
	logic [37:0]           sq_q;
	logic signed [31:0]    ll_q;
	logic [15:0]           post_q;
	result_t               result_q;
	logic                  result_valid_q;

	logic                  ln_start;
	logic [LNW-1:0]        ln_x;
	logic                  ln_done;
	logic signed [LW-1:0]  ln_y;
	logic                  exp_start;
	logic [LW-1:0]         exp_a;
	logic                  exp_done;
	logic [32:0]           exp_y;
	logic                  div_start;
	logic [DW-1:0]         div_num;
	logic [DW-1:0]         div_den;
	logic [5:0]            div_steps;
	logic                  div_done;
	logic [QW-1:0]         div_quo;

	logic                  wr;
	logic                  gidx_ok;
	logic [GW-1:0]         waddr;
	logic [GW-1:0]         raddr;
	logic                  last_k;
	logic [KW-1:0]         kk_nx;
	logic [31:0]           prod;
	logic [25:0]           mn_x;
	logic [25:0]           diff;
	logic [DW-1:0]         quad_num;
	logic                  quad_big;
	logic signed [LW-1:0]  vraw;
	logic signed [LW-1:0]  gv;
	logic signed [LW-1:0]  llw;

	function automatic logic [7:0] prior_sel(input voxel_t v, input logic [2:0] c);
		case (c)
			3'd0: prior_sel = v.prior_c0;
			3'd1: prior_sel = v.prior_c1;
			3'd2: prior_sel = v.prior_c2;
			3'd3: prior_sel = v.prior_c3;
			3'd4: prior_sel = v.prior_c4;
			default: prior_sel = v.prior_c5;
		endcase
	endfunction

	assign voxel_stall  = state_q != S_IDLE;
	assign cfg_ready    = 1'b1;
	assign result       = result_q;
	assign result_valid = result_valid_q;

	assign wr      = state_q == S_IDLE && voxel_valid && voxel.action == ACT_WRITE;
	assign gidx_ok = int'(voxel.param_index) < MAX_GAUSS;
	assign waddr   = GW'(voxel.param_index);
	assign raddr   = k_q[GW-1:0];
	assign last_k  = (k_q + KW'(1)) == kk_q;

	assign prod     = cw_q[c_q] * {prior_sel(item_q, c_q), 8'd1};
	assign mn_x     = 26'(mn_rd_q);
	assign diff     = (x_q >= mn_x) ? x_q - mn_x : mn_x - x_q;
	assign quad_num = DW'({dsq_q, 7'd0});
	assign quad_big = quad_num >= (DW'(var_q) << 41);
	assign vraw     = t_q - $signed(LW'(quad_q));
	assign gv       = (skip_q || vraw < LOG_FLOOR) ? LOG_FLOOR : vraw;
	assign llw      = ln_y - LL_OFS + maxq_q;

	always_comb begin
		if (reg_q[REG_TOTAL] == 5'd0) begin
			kk_nx = KW'(1);
		end else if (int'(reg_q[REG_TOTAL]) > MAX_GAUSS) begin
			kk_nx = KW'(MAX_GAUSS);
		end else begin
			kk_nx = KW'(reg_q[REG_TOTAL]);
		end
	end

	always_comb begin
		ln_start  = 1'b0;
		ln_x      = '0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		div_steps = '0;
		case (state_q)
			S_LSUM_GO: begin
				ln_start = bsum_q != '0;
				ln_x     = LNW'(bsum_q);
			end
			S_LC_GO: begin
				ln_start = bc_q[c_q] != '0;
				ln_x     = LNW'(bc_q[c_q]);
			end
			S_LNV_GO: begin
				ln_start = 1'b1;
				ln_x     = LNW'(var_q);
			end
			S_LNM_GO: begin
				ln_start = 1'b1;
				ln_x     = LNW'(mw_rd_q);
			end
			S_LL_GO: begin
				ln_start = sq_q != '0;
				ln_x     = LNW'(sq_q);
			end
			S_DIV_GO: begin
				div_start = !quad_big;
				div_num   = quad_num;
				div_den   = DW'(var_q) << 40;
				div_steps = 6'd41;
			end
			S_PGO: begin
				div_start = sq_q != '0;
				div_num   = DW'(ex_rd_q) << 16;
				div_den   = DW'(sq_q) << 16;
				div_steps = 6'd17;
			end
			default: begin
			end
		endcase
	end

	assign exp_start = state_q == S_EGO;
	assign exp_a     = LW'(maxq_q - q_rd_q);

	gvp_ln u_ln (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ln_start),
		.x      (ln_x),
		.done   (ln_done),
		.y      (ln_y)
	);

	gvp_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (exp_start),
		.a      (exp_a),
		.done   (exp_done),
		.y      (exp_y)
	);

	gvp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.steps  (div_steps),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		if (wr && gidx_ok && voxel.param_kind == KIND_MIX) begin
			mw_mem[waddr] <= voxel.param_value[15:0];
		end
		if (wr && gidx_ok && voxel.param_kind == KIND_MEAN) begin
			mn_mem[waddr] <= voxel.param_value[23:0];
		end
		if (wr && gidx_ok && voxel.param_kind == KIND_VAR) begin
			var_mem[waddr] <= voxel.param_value;
		end
		mw_rd_q  <= mw_mem[raddr];
		mn_rd_q  <= mn_mem[raddr];
		var_rd_q <= var_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_GSUM2) begin
			q_mem[raddr]   <= gv;
			cls_mem[raddr] <= c_q;
		end
		if (state_q == S_EWT && exp_done) begin
			ex_mem[raddr] <= exp_y;
		end
		q_rd_q   <= q_mem[raddr];
		ex_rd_q  <= ex_mem[raddr];
		cls_rd_q <= cls_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < NUM_REGS; i++) begin
				reg_q[i] <= reg_reset(3'(i));
			end
			for (int i = 0; i < NUM_CLASSES; i++) begin
				cw_q[i]   <= '0;
				bc_q[i]   <= '0;
				logp_q[i] <= '0;
			end
			item_q         <= '0;
			x_q            <= '0;
			c_q            <= '0;
			cum_q          <= '0;
			k_q            <= '0;
			kk_q           <= '0;
			bsum_q         <= '0;
			lnsum_q        <= '0;
			var_q          <= '0;
			dsq_q          <= '0;
			skip_q         <= 1'b0;
			lnv_q          <= '0;
			lnm_q          <= '0;
			quad_q         <= '0;
			t_q            <= '0;
			maxq_q         <= '0;
			sq_q           <= '0;
			ll_q           <= '0;
			post_q         <= '0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && int'(cfg_index) < NUM_REGS) begin
				reg_q[cfg_index] <= cfg_data;
			end
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (wr && voxel.param_kind == KIND_CLASS &&
						int'(voxel.param_index) < NUM_CLASSES) begin
						cw_q[voxel.param_index[2:0]] <= voxel.param_value[15:0];
					end
					if (voxel_valid && voxel.action != ACT_WRITE) begin
						item_q  <= voxel;
						kk_q    <= kk_nx;
						c_q     <= '0;
						bsum_q  <= '0;
						state_q <= S_PRI;
					end
				end
				S_PRI: begin
					if (c_q == 3'd0) begin
						x_q <= 26'((32'(item_q.intensity) * 32'(item_q.bias_gain)) >> 6);
					end
					bc_q[c_q] <= prod;
					bsum_q    <= bsum_q + 35'(prod);
					if (c_q == 3'(NUM_CLASSES - 1)) begin
						c_q     <= '0;
						state_q <= S_LSUM_GO;
					end else begin
						c_q <= c_q + 3'd1;
					end
				end
				S_LSUM_GO: begin
					if (bsum_q == '0) begin
						for (int i = 0; i < NUM_CLASSES; i++) begin
							logp_q[i] <= '0;
						end
						k_q     <= '0;
						cum_q   <= 8'(reg_q[REG_COUNT0]);
						maxq_q  <= LOG_FLOOR;
						state_q <= S_GCLS;
					end else begin
						state_q <= S_LSUM_WT;
					end
				end
				S_LSUM_WT: begin
					if (ln_done) begin
						lnsum_q <= ln_y;
						state_q <= S_LC_GO;
					end
				end
				S_LC_GO: begin
					if (bc_q[c_q] == '0) begin
						logp_q[c_q] <= LOG_FLOOR;
						if (c_q == 3'(NUM_CLASSES - 1)) begin
							c_q     <= '0;
							k_q     <= '0;
							cum_q   <= 8'(reg_q[REG_COUNT0]);
							maxq_q  <= LOG_FLOOR;
							state_q <= S_GCLS;
						end else begin
							c_q <= c_q + 3'd1;
						end
					end else begin
						state_q <= S_LC_WT;
					end
				end
				S_LC_WT: begin
					if (ln_done) begin
						logp_q[c_q] <= ln_y - lnsum_q;
						if (c_q == 3'(NUM_CLASSES - 1)) begin
							c_q     <= '0;
							k_q     <= '0;
							cum_q   <= 8'(reg_q[REG_COUNT0]);
							maxq_q  <= LOG_FLOOR;
							state_q <= S_GCLS;
						end else begin
							c_q     <= c_q + 3'd1;
							state_q <= S_LC_GO;
						end
					end
				end
				S_GCLS: begin
					if (c_q < 3'(NUM_CLASSES - 1) && 8'(k_q) >= cum_q) begin
						c_q   <= c_q + 3'd1;
						cum_q <= cum_q + 8'(reg_q[3'(c_q + 3'd2)]);
					end else begin
						state_q <= S_GMUL;
					end
				end
				S_GMUL: begin
					var_q  <= (var_rd_q == '0) ? 32'd1 : var_rd_q;
					dsq_q  <= diff * diff;
					skip_q <= mw_rd_q == '0 || logp_q[c_q] == LOG_FLOOR;
					if (mw_rd_q == '0 || logp_q[c_q] == LOG_FLOOR) begin
						state_q <= S_GSUM2;
					end else begin
						state_q <= S_LNV_GO;
					end
				end
				S_LNV_GO: state_q <= S_LNV_WT;
				S_LNV_WT: begin
					if (ln_done) begin
						lnv_q   <= ln_y;
						state_q <= S_LNM_GO;
					end
				end
				S_LNM_GO: state_q <= S_LNM_WT;
				S_LNM_WT: begin
					if (ln_done) begin
						lnm_q   <= ln_y;
						state_q <= S_DIV_GO;
					end
				end
				S_DIV_GO: begin
					if (quad_big) begin
						quad_q  <= QUAD_CAP;
						state_q <= S_GSUM1;
					end else begin
						state_q <= S_DIV_WT;
					end
				end
				S_DIV_WT: begin
					if (div_done) begin
						quad_q  <= (div_quo > QUAD_CAP) ? QUAD_CAP : div_quo;
						state_q <= S_GSUM1;
					end
				end
				S_GSUM1: begin
					t_q     <= lnm_q + GAUSS_OFS - (lnv_q >>> 1) + logp_q[c_q];
					state_q <= S_GSUM2;
				end
				S_GSUM2: begin
					if (gv > maxq_q) begin
						maxq_q <= gv;
					end
					if (last_k) begin
						k_q     <= '0;
						sq_q    <= '0;
						state_q <= S_ERD;
					end else begin
						k_q     <= k_q + KW'(1);
						state_q <= S_GCLS;
					end
				end
				S_ERD: state_q <= S_EGO;
				S_EGO: state_q <= S_EWT;
				S_EWT: begin
					if (exp_done) begin
						sq_q <= sq_q + 38'(exp_y);
						if (last_k) begin
							k_q     <= '0;
							state_q <= S_LL_GO;
						end else begin
							k_q     <= k_q + KW'(1);
							state_q <= S_ERD;
						end
					end
				end
				S_LL_GO: begin
					if (sq_q == '0) begin
						ll_q    <= 32'sh8000_0000;
						state_q <= S_PRD;
					end else begin
						state_q <= S_LL_WT;
					end
				end
				S_LL_WT: begin
					if (ln_done) begin
						if (llw > LL_MAX) begin
							ll_q <= 32'sh7FFF_FFFF;
						end else if (llw < LL_MIN) begin
							ll_q <= 32'sh8000_0000;
						end else begin
							ll_q <= llw[31:0];
						end
						state_q <= S_PRD;
					end
				end
				S_PRD: state_q <= S_PGO;
				S_PGO: begin
					if (sq_q == '0) begin
						post_q  <= '0;
						state_q <= S_POUT;
					end else begin
						state_q <= S_PWT;
					end
				end
				S_PWT: begin
					if (div_done) begin
						post_q  <= (div_quo > QW'(16'hFFFF)) ? 16'hFFFF : div_quo[15:0];
						state_q <= S_POUT;
					end
				end
				S_POUT: begin
					if (!result_valid_q || !result_stall) begin
						result_q.gaussian_index <= 4'(k_q);
						result_q.class_index    <= cls_rd_q;
						result_q.posterior      <= post_q;
						result_q.log_likelihood <= last_k ? ll_q : 32'sd0;
						result_q.last           <= last_k;
						result_valid_q          <= 1'b1;
						if (last_k) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + KW'(1);
							state_q <= S_PRD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/gvp_ln.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gvp_ln: natural logarithm unit
// Normalizes the operand a byte or a bit per cycle, then runs sixteen
// shift-and-add steps against the ln(1+2^-i) table. Result is signed Q32.16.
// ----------------------------------------------------------------------------
module gvp_ln (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [gvp_pkg::LNW-1:0]          x,
	output logic                                  done,
	output logic signed [gvp_pkg::LW-1:0]         y
);
	import gvp_pkg::*;

	typedef enum logic [1:0] {L_IDLE, L_NORM, L_ITER, L_FIN} ln_state_t;

	ln_state_t             state_q;
	logic [LNW-1:0]        nx_q;
	logic [5:0]            e_q;
	logic [32:0]           m_q;
	logic [16:0]           r_q;
	logic [4:0]            i_q;
	logic                  done_q;
	logic signed [LW-1:0]  y_q;
	logic [33:0]           t;

	assign t    = 34'(m_q) + 34'(m_q >> i_q);
	assign done = done_q;
	assign y    = y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			nx_q    <= '0;
			e_q     <= '0;
			m_q     <= '0;
			r_q     <= '0;
			i_q     <= '0;
			done_q  <= 1'b0;
			y_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				L_IDLE: begin
					if (start) begin
						nx_q    <= x;
						e_q     <= 6'd39;
						state_q <= L_NORM;
					end
				end
				L_NORM: begin
					if (nx_q[LNW-1] || e_q == 6'd0) begin
						m_q     <= nx_q[LNW-1:LNW-33];
						r_q     <= '0;
						i_q     <= 5'd1;
						state_q <= L_ITER;
					end else if (nx_q[LNW-1:LNW-8] == 8'd0 && e_q >= 6'd8) begin
						nx_q <= nx_q << 8;
						e_q  <= e_q - 6'd8;
					end else begin
						nx_q <= nx_q << 1;
						e_q  <= e_q - 6'd1;
					end
				end
				L_ITER: begin
					if (!t[33]) begin
						m_q <= t[32:0];
						r_q <= r_q + ln_tab(i_q);
					end
					if (i_q == 5'd16) begin
						state_q <= L_FIN;
					end else begin
						i_q <= i_q + 5'd1;
					end
				end
				L_FIN: begin
					y_q     <= $signed((LW'(e_q) + LW'(1)) * LW'(LN2_VAL) - LW'(r_q));
					done_q  <= 1'b1;
					state_q <= L_IDLE;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/gvp_exp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gvp_exp: exp(-a) unit
// Splits a into a multiple of ln 2 and a remainder by six restoring steps,
// runs sixteen table steps on the remainder and shifts the Q2.30 result;
// an operand of 40 ln 2 or more gives zero at once.
module gvp_exp (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [gvp_pkg::LW-1:0]   a,
	output logic                          done,
	output logic [32:0]                   y
);
	import gvp_pkg::*;

	typedef enum logic [1:0] {X_IDLE, X_DIV, X_ITER, X_FIN} exp_state_t;

	exp_state_t   state_q;
	logic [20:0]  rem_q;
	logic [5:0]   n_q;
	logic [2:0]   j_q;
	logic [16:0]  s_q;
	logic [32:0]  w_q;
	logic [4:0]   i_q;
	logic         done_q;
	logic [32:0]  y_q;
	logic [20:0]  dsub;
	logic [20:0]  rem_nx;
	logic         ge;
	logic [16:0]  tab;

	assign dsub   = 21'(LN2_VAL) << j_q;
	assign ge     = rem_q >= dsub;
	assign rem_nx = ge ? rem_q - dsub : rem_q;
	assign tab    = ln_tab(i_q);
	assign done   = done_q;
	assign y      = y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= X_IDLE;
			rem_q   <= '0;
			n_q     <= '0;
			j_q     <= '0;
			s_q     <= '0;
			w_q     <= '0;
			i_q     <= '0;
			done_q  <= 1'b0;
			y_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				X_IDLE: begin
					if (start) begin
						if (a >= LW'(EXP_LIMIT)) begin
							y_q    <= '0;
							done_q <= 1'b1;
						end else begin
							rem_q   <= a[20:0];
							n_q     <= '0;
							j_q     <= 3'd5;
							state_q <= X_DIV;
						end
					end
				end
				X_DIV: begin
					rem_q <= rem_nx;
					if (ge) begin
						n_q[j_q] <= 1'b1;
					end
					if (j_q == 3'd0) begin
						s_q     <= 17'(LN2_VAL) - 17'(rem_nx);
						w_q     <= 33'd1 << 30;
						i_q     <= 5'd1;
						state_q <= X_ITER;
					end else begin
						j_q <= j_q - 3'd1;
					end
				end
				X_ITER: begin
					if (s_q >= tab) begin
						s_q <= s_q - tab;
						w_q <= w_q + (w_q >> i_q);
					end
					if (i_q == 5'd16) begin
						state_q <= X_FIN;
					end else begin
						i_q <= i_q + 5'd1;
					end
				end
				X_FIN: begin
					y_q     <= w_q >> ({1'b0, n_q} + 7'd1);
					done_q  <= 1'b1;
					state_q <= X_IDLE;
				end
				default: state_q <= X_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/gvp_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gvp_div: restoring divider
// One quotient bit per cycle. The caller hands in the divisor already
// aligned to the top quotient bit and the number of quotient bits.
// ----------------------------------------------------------------------------
module gvp_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [gvp_pkg::DW-1:0]   num,
	input  wire logic [gvp_pkg::DW-1:0]   den,
	input  wire logic [5:0]               steps,
	output logic                          done,
	output logic [gvp_pkg::QW-1:0]        quo
);
	import gvp_pkg::*;

	logic           busy_q;
	logic           done_q;
	logic [5:0]     cnt_q;
	logic [DW-1:0]  rem_q;
	logic [DW-1:0]  den_q;
	logic [QW-1:0]  quo_q;
	logic           ge;

	assign ge   = rem_q >= den_q;
	assign done = done_q;
	assign quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				if (ge) begin
					rem_q <= rem_q - den_q;
				end
				quo_q <= {quo_q[QW-2:0], ge};
				den_q <= den_q >> 1;
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (start) begin
				rem_q  <= num;
				den_q  <= den;
				quo_q  <= '0;
				cnt_q  <= steps;
				busy_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for gmm_voxel_posterior
// Loads the mixture table through parameter write requests, classifies
// voxels under several Gaussian and class count settings, and compares each
// posterior result with a bit-exact fixed-point predictor of the block.
// ----------------------------------------------------------------------------
module tb;
	import gvp_pkg::*;

	localparam logic ACT_VOXEL = 1'b1;
	localparam longint LN2_C = 45426;
	localparam longint HALF_LN_2PI = 60224;
	localparam longint FLOOR_C = -(64'sd1 <<< 40);
	localparam int SETTLE = 2000;
	localparam int WATCHDOG = 30000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic voxel_valid = 1'b0;
	logic voxel_stall;
	voxel_t voxel = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [4:0] cfg_data = '0;

	gmm_voxel_posterior dut (
		.clk(clk), .arst_n(arst_n),
		.voxel_valid(voxel_valid), .voxel_stall(voxel_stall), .voxel(voxel),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	voxel_t pending_req[$];
	result_t expected_post[$];
	logic [4:0] count_reg[7] = '{5'd12, 5'd1, 5'd1, 5'd1, 5'd3, 5'd4, 5'd2};
	logic [15:0] mix_w[16];
	logic [23:0] mean_w[16];
	logic [31:0] var_w[16];
	logic [15:0] class_w[6];
	int errors = 0;
	int n_voxels = 0;
	int n_results = 0;
	int n_settings = 1;
	logic squeeze = 1'b0;

	function automatic longint ln_step(input int i);
		case (i)
			1: return 26573; 2: return 14624; 3: return 7719; 4: return 3973;
			5: return 2017; 6: return 1016; 7: return 510; 8: return 256;
			9: return 128; 10: return 64; 11: return 32; 12: return 16;
			13: return 8; 14: return 4; 15: return 2; 16: return 1;
			default: return 45426;
		endcase
	endfunction

	function automatic longint ln_q16(input longint unsigned x);
		int e;
		longint unsigned m, t;
		longint r;
		e = 62;
		r = 0;
		while (e > 0 && x[e] == 1'b0) e--;
		if (e <= 32) m = x << (32 - e);
		else m = x >> (e - 32);
		for (int i = 1; i <= 16; i++) begin
			t = m + (m >> i);
			if (t < (64'd1 << 33)) begin
				m = t;
				r += ln_step(i);
			end
		end
		return longint'(e) * LN2_C + LN2_C - r;
	endfunction

	function automatic longint unsigned exp_decay(input longint a);
		longint n, s;
		longint unsigned y;
		n = a / LN2_C;
		s = LN2_C - (a - n * LN2_C);
		y = 64'd1 << 30;
		if (n + 1 > 40) return 0;
		for (int i = 1; i <= 16; i++) begin
			if (s >= ln_step(i)) begin
				s -= ln_step(i);
				y += y >> i;
			end
		end
		return y >> (n + 1);
	endfunction

	task automatic predict_posteriors(input voxel_t v);
		longint logp[6], q[16];
		longint unsigned ex[16], bc[6], bsum, sq, x, diff, quad, vr, post;
		logic [7:0] pr[6];
		int cls[16];
		longint maxq, ll, val;
		int kk, c, cum;
		result_t r;
		if (v.action == ACT_WRITE) begin
			case (v.param_kind)
				KIND_MIX: mix_w[v.param_index] = v.param_value[15:0];
				KIND_MEAN: mean_w[v.param_index] = v.param_value[23:0];
				KIND_VAR: var_w[v.param_index] = v.param_value;
				default: if (v.param_index < 6) class_w[v.param_index] = v.param_value[15:0];
			endcase
			return;
		end
		n_voxels++;
		pr = '{v.prior_c0, v.prior_c1, v.prior_c2, v.prior_c3, v.prior_c4, v.prior_c5};
		kk = count_reg[REG_TOTAL];
		if (kk < 1) kk = 1;
		if (kk > 16) kk = 16;
		bsum = 0;
		for (int i = 0; i < 6; i++) begin
			bc[i] = 64'(class_w[i]) * (64'(pr[i]) * 256 + 1);
			bsum += bc[i];
		end
		for (int i = 0; i < 6; i++) begin
			if (bsum == 0) logp[i] = 0;
			else if (bc[i] == 0) logp[i] = FLOOR_C;
			else logp[i] = ln_q16(bc[i]) - ln_q16(bsum);
		end
		x = (64'(v.intensity) * 64'(v.bias_gain)) >> 6;
		c = 0;
		cum = count_reg[REG_COUNT0];
		maxq = FLOOR_C;
		for (int k = 0; k < kk; k++) begin
			while (c < 5 && k >= cum) begin
				c++;
				cum += count_reg[1 + c];
			end
			cls[k] = c;
			vr = (var_w[k] == 0) ? 64'd1 : 64'(var_w[k]);
			diff = (x >= mean_w[k]) ? x - mean_w[k] : 64'(mean_w[k]) - x;
			quad = ((diff * diff) << 7) / vr;
			if (quad > (64'd1 << 40)) quad = 64'd1 << 40;
			if (mix_w[k] == 0 || logp[c] == FLOOR_C) begin
				val = FLOOR_C;
			end else begin
				val = ln_q16(mix_w[k]) - 16 * LN2_C - HALF_LN_2PI - (ln_q16(vr) >>> 1)
					+ 4 * LN2_C - longint'(quad) + logp[c];
				if (val < FLOOR_C) val = FLOOR_C;
			end
			q[k] = val;
			if (val > maxq) maxq = val;
		end
		sq = 0;
		for (int k = 0; k < kk; k++) begin
			ex[k] = exp_decay(maxq - q[k]);
			sq += ex[k];
		end
		if (sq == 0) begin
			ll = -64'sd2147483648;
		end else begin
			ll = ln_q16(sq) - 30 * LN2_C + maxq;
			if (ll > 64'sd2147483647) ll = 64'sd2147483647;
			if (ll < -64'sd2147483648) ll = -64'sd2147483648;
		end
		for (int k = 0; k < kk; k++) begin
			post = 0;
			if (sq != 0) begin
				post = (ex[k] << 16) / sq;
				if (post > 64'hFFFF) post = 64'hFFFF;
			end
			r.gaussian_index = 4'(k);
			r.class_index = 3'(cls[k]);
			r.posterior = post[15:0];
			r.log_likelihood = (k == kk - 1) ? ll[31:0] : 32'd0;
			r.last = (k == kk - 1);
			expected_post.push_back(r);
		end
	endtask

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	// driver: bursts with random gaps, payload held while stalled
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voxel_valid <= 1'b0;
			voxel <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (voxel_valid && !voxel_stall) predict_posteriors(voxel);
			if (!voxel_valid || !voxel_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					voxel_valid <= 1'b0;
				end else if (pending_req.size() > 0) begin
					voxel <= pending_req.pop_front();
					voxel_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 12);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					voxel_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern, with one long hold-off
	int hold_left = 0;
	int mode = 0;
	int mode_left = 0;
	logic squeezed = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_left <= 0;
			squeezed <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else if (squeeze && !squeezed) begin
			squeezed <= 1'b1;
			hold_left <= 3000;
			result_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				mode <= $urandom_range(0, 2);
				mode_left <= $urandom_range(20, 200);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (mode)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(0, 3) == 0);
				default: result_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			n_results++;
			if (expected_post.size() == 0) begin
				report("unexpected result, gaussian", result.gaussian_index, -1);
			end else begin
				result_t w;
				w = expected_post.pop_front();
				if (result.gaussian_index !== w.gaussian_index)
					report("gaussian_index", result.gaussian_index, w.gaussian_index);
				if (result.class_index !== w.class_index)
					report("class_index", result.class_index, w.class_index);
				if (result.posterior !== w.posterior)
					report("posterior", result.posterior, w.posterior);
				if (result.log_likelihood !== w.log_likelihood)
					report("log_likelihood", result.log_likelihood, w.log_likelihood);
				if (result.last !== w.last)
					report("last", result.last, w.last);
			end
		end
	end

	// watchdog on cycles without any accepted transfer
	int quiet = 0;
	always @(posedge clk) begin
		if ((voxel_valid && !voxel_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= WATCHDOG) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	function automatic voxel_t param_req(input logic [1:0] kind, input logic [3:0] idx,
			input logic [31:0] value);
		voxel_t v;
		v = $bits(voxel_t)'({$urandom, $urandom, $urandom, $urandom});
		v.action = ACT_WRITE;
		v.param_kind = kind;
		v.param_index = idx;
		v.param_value = value;
		return v;
	endfunction

	function automatic voxel_t voxel_req(input logic [15:0] inten, input logic [15:0] gain,
			input logic [47:0] priors);
		voxel_t v;
		v = $bits(voxel_t)'({$urandom, $urandom, $urandom, $urandom});
		v.action = ACT_VOXEL;
		v.intensity = inten;
		v.bias_gain = gain;
		{v.prior_c0, v.prior_c1, v.prior_c2, v.prior_c3, v.prior_c4, v.prior_c5} = priors;
		return v;
	endfunction

	function automatic logic [31:0] rand_var();
		return $urandom >> $urandom_range(0, 28);
	endfunction

	task automatic load_table();
		for (int g = 0; g < 16; g++) begin
			pending_req.push_back(param_req(KIND_MIX, 4'(g), $urandom_range(1, 65535)));
			pending_req.push_back(param_req(KIND_MEAN, 4'(g), $urandom));
			pending_req.push_back(param_req(KIND_VAR, 4'(g), rand_var()));
		end
		for (int c = 0; c < 6; c++)
			pending_req.push_back(param_req(KIND_CLASS, 4'(c), $urandom_range(1, 65535)));
	endtask

	task automatic add_random(input int n);
		int g, pick;
		logic [15:0] gain, inten;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 19);
			g = $urandom_range(0, 15);
			if (pick < 2) begin
				pending_req.push_back(param_req(KIND_MIX, 4'(g),
					($urandom_range(0, 7) == 0) ? 32'd0 : $urandom));
			end else if (pick < 3) begin
				pending_req.push_back(param_req(KIND_MEAN, 4'(g), $urandom));
			end else if (pick < 4) begin
				pending_req.push_back(param_req(KIND_VAR, 4'(g), rand_var()));
			end else if (pick < 5) begin
				pending_req.push_back(param_req(KIND_CLASS, 4'($urandom_range(0, 15)),
					$urandom_range(0, 65535)));
			end else begin
				if ($urandom_range(0, 3) != 0) begin
					gain = 16'd16384;
					inten = 16'(mean_w[g] >> 8) + 16'($urandom_range(0, 15)) - 16'd8;
				end else begin
					gain = $urandom;
					inten = $urandom;
				end
				pending_req.push_back(voxel_req(inten, gain, {$urandom, 16'($urandom)}));
			end
		end
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_req.size() != 0 || voxel_valid || expected_post.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_counts(input logic [4:0] vals[7]);
		for (int i = 0; i < 7; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= vals[i];
			do @(posedge clk);
			while (!(cfg_valid && cfg_ready));
			count_reg[i] = vals[i];
		end
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	initial begin
		logic [4:0] cv[7];
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_table();
		pending_req.push_back(voxel_req(16'd0, 16'd0, 48'd0));
		pending_req.push_back(voxel_req(16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF));
		pending_req.push_back(voxel_req(16'hFFFF, 16'd0, 48'hFF00_FF00_FF00));
		pending_req.push_back(voxel_req(16'd0, 16'hFFFF, 48'h00FF_00FF_00FF));
		pending_req.push_back(param_req(KIND_VAR, 4'd0, 32'd0));
		pending_req.push_back(param_req(KIND_VAR, 4'd15, 32'hFFFF_FFFF));
		pending_req.push_back(param_req(KIND_MIX, 4'd1, 32'd0));
		pending_req.push_back(param_req(KIND_MEAN, 4'd2, 32'hFFFF_FFFF));
		pending_req.push_back(param_req(KIND_CLASS, 4'd2, 32'd0));
		pending_req.push_back(param_req(KIND_CLASS, 4'd6, 32'd0));
		pending_req.push_back(param_req(KIND_CLASS, 4'd15, 32'd0));
		pending_req.push_back(voxel_req(16'd1000, 16'd16384, 48'h8080_8080_8080));
		for (int c = 0; c < 6; c++)
			pending_req.push_back(param_req(KIND_CLASS, 4'(c), 32'd0));
		pending_req.push_back(voxel_req(16'd200, 16'd16384, 48'h1020_3040_5060));
		for (int c = 0; c < 6; c++)
			pending_req.push_back(param_req(KIND_CLASS, 4'(c), $urandom_range(1, 65535)));
		pending_req.push_back(voxel_req(16'd1234, 16'd20000, 48'h0000_00FF_0000));

		squeeze <= 1'b1;
		add_random(60);
		wait_idle();

		cv = '{5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1};
		set_counts(cv);
		add_random(40);
		wait_idle();

		cv = '{5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16};
		set_counts(cv);
		add_random(30);
		wait_idle();

		cv = '{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
		set_counts(cv);
		add_random(30);
		wait_idle();

		cv = '{5'd31, 5'd3, 5'd3, 5'd3, 5'd3, 5'd2, 5'd31};
		set_counts(cv);
		add_random(40);
		wait_idle();

		for (int p = 0; p < 2; p++) begin
			for (int i = 0; i < 7; i++) cv[i] = $urandom_range(1, 16);
			set_counts(cv);
			add_random(30);
			wait_idle();
		end

		$display("covered %0d voxels, %0d posterior results, %0d count settings",
			n_voxels, n_results, n_settings);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/gvp_pkg.sv
rtl/gvp_ln.sv
rtl/gvp_exp.sv
rtl/gvp_div.sv
rtl/gmm_voxel_posterior.sv
dv/tb.sv
